[design/scan_line_color_converter_unit_defines.svh]
// ----------------------------------------------------------------------------
// Scan line color converter assertion macros
// Shared concurrent assertion forms for the converter's own checks.
// ----------------------------------------------------------------------------
`ifndef SCAN_LINE_COLOR_CONVERTER_UNIT_DEFINES_SVH
`define SCAN_LINE_COLOR_CONVERTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCLC_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCLC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sclc_pkg.sv]
// ----------------------------------------------------------------------------
// Scan line color converter package
// Color mode codes, fixed-point coefficients, stage records and helpers.
// ----------------------------------------------------------------------------
package sclc_pkg;

  typedef enum logic [2:0] {
    MODE_GREY   = 3'd0,
    MODE_RGB    = 3'd1,
    MODE_GBR    = 3'd2,
    MODE_YUV422 = 3'd3,
    MODE_YUV420 = 3'd4,
    MODE_PAIRED = 3'd5
  } mode_t;

  localparam logic signed [9:0]  CHROMA_OFFSET = 10'sd128;
  localparam logic signed [15:0] COEF_R_CR     = 16'sd45;
  localparam logic signed [15:0] COEF_G_CB     = 16'sd11;
  localparam logic signed [15:0] COEF_G_CR     = 16'sd23;
  localparam logic signed [15:0] COEF_B_CB     = 16'sd113;
  localparam logic signed [15:0] BIAS_DIV32    = 16'sd31;
  localparam logic signed [15:0] BIAS_DIV64    = 16'sd63;
  localparam logic signed [11:0] BYTE_MAX      = 12'sd255;

  typedef struct packed {
    logic [8:0] index;
    logic       two;
    logic       yuv;
    logic [7:0] y0;
    logic [7:0] y1;
    logic [7:0] cr;
    logic [7:0] cb;
    logic [7:0] pr;
    logic [7:0] pg;
    logic [7:0] pb;
  } conv_req_t;

  typedef struct packed {
    logic [8:0] index;
    logic       two;
    logic [7:0] r0;
    logic [7:0] g0;
    logic [7:0] b0;
    logic [7:0] r1;
    logic [7:0] g1;
    logic [7:0] b1;
  } conv_res_t;

  // Division by 32 that truncates toward zero.
  function automatic logic signed [15:0] div_by_32(input logic signed [15:0] p);
    logic signed [15:0] biased;
    biased = p + (p[15] ? BIAS_DIV32 : 16'sd0);
    return biased >>> 5;
  endfunction

  // Division by 64 that truncates toward zero.
  function automatic logic signed [15:0] div_by_64(input logic signed [15:0] p);
    logic signed [15:0] biased;
    biased = p + (p[15] ? BIAS_DIV64 : 16'sd0);
    return biased >>> 6;
  endfunction

  function automatic logic [7:0] clamp_byte(input logic signed [11:0] v);
    logic [7:0] res;
    if (v[11]) begin
      res = 8'd0;
    end else if (v > BYTE_MAX) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

[design/sclc_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sclc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/sclc_yuv_stage.sv]
// ----------------------------------------------------------------------------
// Scan line color converter YUV stage
// Registers the chroma products, then divides, adds luma and clamps.
// ----------------------------------------------------------------------------
module sclc_yuv_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_valid,
  input  sclc_pkg::conv_req_t  req,
  output logic                 req_ready,
  output logic                 res_valid,
  output sclc_pkg::conv_res_t  res,
  input  logic                 res_ready
);
  import sclc_pkg::*;

  logic               valid_r;
  logic [8:0]         index_r;
  logic               two_r;
  logic               yuv_r;
  logic [7:0]         y0_r;
  logic [7:0]         y1_r;
  logic [7:0]         pr_r;
  logic [7:0]         pg_r;
  logic [7:0]         pb_r;
  logic signed [15:0] rp_r;
  logic signed [15:0] gp_r;
  logic signed [15:0] bp_r;

  logic signed [9:0]  cr_s;
  logic signed [9:0]  cb_s;
  logic signed [15:0] cr16;
  logic signed [15:0] cb16;
  logic signed [15:0] rp_nxt;
  logic signed [15:0] gp_nxt;
  logic signed [15:0] bp_nxt;

  logic signed [11:0] r_off;
  logic signed [11:0] g_off;
  logic signed [11:0] b_off;
  logic signed [11:0] y0_s;
  logic signed [11:0] y1_s;

  assign req_ready = !valid_r || res_ready;

  assign cr_s   = $signed({2'b00, req.cr}) - CHROMA_OFFSET;
  assign cb_s   = $signed({2'b00, req.cb}) - CHROMA_OFFSET;
  assign cr16   = 16'(cr_s);
  assign cb16   = 16'(cb_s);
  assign rp_nxt = cr16 * COEF_R_CR;
  assign gp_nxt = cb16 * COEF_G_CB + cr16 * COEF_G_CR;
  assign bp_nxt = cb16 * COEF_B_CB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (req_ready) begin
      valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready) begin
      index_r <= req.index;
      two_r   <= req.two;
      yuv_r   <= req.yuv;
      y0_r    <= req.y0;
      y1_r    <= req.y1;
      pr_r    <= req.pr;
      pg_r    <= req.pg;
      pb_r    <= req.pb;
      rp_r    <= rp_nxt;
      gp_r    <= gp_nxt;
      bp_r    <= bp_nxt;
    end
  end

  assign r_off = 12'(div_by_32(rp_r));
  assign g_off = 12'(div_by_32(gp_r));
  assign b_off = 12'(div_by_64(bp_r));
  assign y0_s  = $signed({4'b0000, y0_r});
  assign y1_s  = $signed({4'b0000, y1_r});

  always_comb begin
    res       = '0;
    res.index = index_r;
    res.two   = two_r;
    if (yuv_r) begin
      res.r0 = clamp_byte(y0_s + r_off);
      res.g0 = clamp_byte(y0_s - g_off);
      res.b0 = clamp_byte(y0_s + b_off);
      res.r1 = clamp_byte(y1_s + r_off);
      res.g1 = clamp_byte(y1_s - g_off);
      res.b1 = clamp_byte(y1_s + b_off);
    end else begin
      res.r0 = pr_r;
      res.g0 = pg_r;
      res.b0 = pb_r;
      res.r1 = pr_r;
      res.g1 = pg_r;
      res.b1 = pb_r;
    end
  end

  assign res_valid = valid_r;

endmodule

[design/sclc_out_buf.sv]
// ----------------------------------------------------------------------------
// Scan line color converter output buffer
// Holds one converted item and hands out its one or two rows in order.
// ----------------------------------------------------------------------------
module sclc_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_valid,
  input  sclc_pkg::conv_res_t  res,
  output logic                 res_ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [8:0]           out_index,
  output logic                 out_row,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic                 out_last
);
  import sclc_pkg::*;

  logic      valid_r;
  logic      sent_r;
  conv_res_t data_r;
  logic      second;
  logic      take;

  assign second    = data_r.two && sent_r;
  assign take      = valid_r && !out_stall;
  assign out_valid = valid_r;
  assign out_index = data_r.index;
  assign out_row   = second;
  assign out_last  = !data_r.two || sent_r;
  assign out_red   = second ? data_r.r1 : data_r.r0;
  assign out_green = second ? data_r.g1 : data_r.g0;
  assign out_blue  = second ? data_r.b1 : data_r.b0;
  assign res_ready = !valid_r || (take && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sent_r  <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
      sent_r  <= 1'b0;
    end else if (take) begin
      sent_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready) begin
      data_r <= res;
    end
  end

endmodule

[design/scan_line_color_converter_unit.sv]
// ----------------------------------------------------------------------------
// Scan line color converter
// Turns decoded scan line pixels into RGB rows in one of six color modes.
//
//   channel | handshake         | payload
//   --------+-------------------+-----------------------------------------
//   in      | in_valid/in_stall | pixel_index, odd_line, comp0..comp3
//   out     | out_valid/out_stall | out_index, row, red, green, blue, last
//   cfg     | cfg_wr_en         | cfg_wr_data (color mode)
//
// The first row of an item is presented once the item has passed stage one,
// stage two, the YUV stage and the output buffer.
// One item per cycle in the single-row modes while the output does not stall;
// two-row items hold the single result port until both rows are sent.
// Reset clears the pipeline and sets grey mode; the line store is not cleared.
// A stall on the output holds every full stage; empty stages still fill.
// ----------------------------------------------------------------------------
`include "scan_line_color_converter_unit_defines.svh"

module scan_line_color_converter_unit #(
  parameter int LINE_PIXELS = 512
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [8:0] in_pixel_index,
  input  logic       in_odd_line,
  input  logic [7:0] in_comp0,
  input  logic [7:0] in_comp1,
  input  logic [7:0] in_comp2,
  input  logic [7:0] in_comp3,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [8:0] out_index,
  output logic       out_row,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_last
);
  import sclc_pkg::*;

  localparam int AW = $clog2(LINE_PIXELS);
  localparam logic [20:0] RECIP = 21'((2 ** 20 + LINE_PIXELS - 1) / LINE_PIXELS);

  logic [2:0]  color_mode_r;

  logic        v1_r;
  logic [8:0]  idx1_r;
  logic        odd1_r;
  logic [7:0]  c0_1_r;
  logic [7:0]  c1_1_r;
  logic [7:0]  c2_1_r;
  logic [7:0]  c3_1_r;
  logic [8:0]  q1_r;

  logic        v2_r;
  logic [8:0]  idx2_r;
  logic [7:0]  c0_2_r;
  logic [7:0]  c1_2_r;
  logic [7:0]  c2_2_r;
  logic [7:0]  c3_2_r;

  logic        accept;
  logic        mode_ok;
  logic        rdy1;
  logic        rdy2;
  logic        rdy3;
  logic        move12;
  logic        is_420;
  logic        store_wr;
  logic        store_rd;
  logic [29:0] quot_prod;
  logic [19:0] slot_full;
  logic [AW-1:0] slot;
  logic [15:0] store_rd_data;

  conv_req_t   req;
  logic        res_valid;
  conv_res_t   res;
  logic        res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= MODE_GREY;
    end else if (cfg_wr_en) begin
      color_mode_r <= cfg_wr_data;
    end
  end

  assign mode_ok   = (color_mode_r <= MODE_PAIRED);
  assign is_420    = (color_mode_r == MODE_YUV420);
  assign rdy1      = !v1_r || rdy2;
  assign rdy2      = !v2_r || rdy3;
  assign in_stall  = !rdy1;
  assign accept    = in_valid && rdy1;
  assign move12    = v1_r && rdy2;
  assign quot_prod = {21'd0, in_pixel_index} * {9'd0, RECIP};
  assign slot_full = 20'(idx1_r) - 20'(q1_r) * 20'(LINE_PIXELS);
  assign slot      = slot_full[AW-1:0];
  assign store_wr  = move12 && is_420 && !odd1_r;
  assign store_rd  = move12 && is_420 && odd1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= accept && mode_ok;
      end
      if (rdy2) begin
        v2_r <= v1_r && !(is_420 && !odd1_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      idx1_r <= in_pixel_index;
      odd1_r <= in_odd_line;
      c0_1_r <= in_comp0;
      c1_1_r <= in_comp1;
      c2_1_r <= in_comp2;
      c3_1_r <= in_comp3;
      q1_r   <= quot_prod[28:20];
    end
    if (rdy2) begin
      idx2_r <= idx1_r;
      c0_2_r <= c0_1_r;
      c1_2_r <= c1_1_r;
      c2_2_r <= c2_1_r;
      c3_2_r <= c3_1_r;
    end
  end

  sclc_ram #(
    .WIDTH(16),
    .DEPTH(LINE_PIXELS)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (slot),
    .wr_data ({c1_1_r, c0_1_r}),
    .rd_en   (store_rd),
    .rd_addr (slot),
    .rd_data (store_rd_data)
  );

  always_comb begin
    req       = '0;
    req.index = idx2_r;
    case (color_mode_r)
      MODE_GREY: begin
        req.pr = c0_2_r;
        req.pg = c0_2_r;
        req.pb = c0_2_r;
      end
      MODE_RGB: begin
        req.pr = c0_2_r;
        req.pg = c1_2_r;
        req.pb = c2_2_r;
      end
      MODE_GBR: begin
        req.pr = c2_2_r;
        req.pg = c0_2_r;
        req.pb = c1_2_r;
      end
      MODE_YUV422: begin
        req.yuv = 1'b1;
        req.y0  = c0_2_r;
        req.y1  = c0_2_r;
        req.cr  = c1_2_r;
        req.cb  = c2_2_r;
      end
      MODE_YUV420: begin
        req.yuv = 1'b1;
        req.two = 1'b1;
        req.y0  = store_rd_data[7:0];
        req.y1  = c0_2_r;
        req.cr  = store_rd_data[15:8];
        req.cb  = c1_2_r;
      end
      MODE_PAIRED: begin
        req.yuv = 1'b1;
        req.two = 1'b1;
        req.y0  = c0_2_r;
        req.y1  = c3_2_r;
        req.cr  = c1_2_r;
        req.cb  = c2_2_r;
      end
      default: begin
        req.yuv = 1'b0;
      end
    endcase
  end

  sclc_yuv_stage u_yuv_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (v2_r),
    .req       (req),
    .req_ready (rdy3),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  sclc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_index (out_index),
    .out_row   (out_row),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_last  (out_last)
  );

  `SCLC_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, in_stall, v1_r, "input stalled with stage one empty")
  `SCLC_ASSERT_NEXT(a_second_row_follows, clk, rst_n, out_valid && !out_last && !out_stall, out_valid && out_row, "second row did not follow the first")
  `SCLC_ASSERT_NEXT(a_unused_mode_dropped, clk, rst_n, accept && !mode_ok, !v1_r, "item in an unused mode entered the pipeline")

endmodule

[tb/sv/scan_line_color_converter_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan line color converter testbench
// Drives decoded pixels through every color mode and compares each RGB item
// with a predictor that tracks the mode register and the YUV420 line store.
// The sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module scan_line_color_converter_unit_test;
  import sclc_pkg::*;

  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;
  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    logic [8:0] index;
    logic       row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } rgb_item_t;

  typedef enum {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

  class pixel_scoreboard;
    logic [2:0]  color_mode;
    logic [15:0] line_store [512];
    bit          store_valid [512];
    rgb_item_t   pending_rgb [$];
    int          errors;

    function new();
      color_mode = MODE_GREY;
      errors = 0;
      foreach (store_valid[i]) store_valid[i] = 1'b0;
    endfunction

    function void queue_rgb(rgb_item_t px);
      pending_rgb.insert(pending_rgb.size(), px);
    endfunction

    function rgb_item_t yuv_to_rgb(logic [8:0] idx, logic row, logic last,
                                   logic [7:0] y, logic [7:0] cr_byte, logic [7:0] cb_byte);
      int luma;
      int cr;
      int cb;
      int chan [3];
      rgb_item_t px;
      luma = int'(y);
      cr = int'(cr_byte) - 128;
      cb = int'(cb_byte) - 128;
      chan[0] = luma + (45 * cr) / 32;
      chan[1] = luma - (11 * cb + 23 * cr) / 32;
      chan[2] = luma + (113 * cb) / 64;
      foreach (chan[i]) chan[i] = (chan[i] < 0) ? 0 : (chan[i] > 255) ? 255 : chan[i];
      px = '{idx, row, 8'(chan[0]), 8'(chan[1]), 8'(chan[2]), last};
      return px;
    endfunction

    function void note_pixel(logic [8:0] idx, logic odd, logic [7:0] c0, logic [7:0] c1,
                             logic [7:0] c2, logic [7:0] c3);
      rgb_item_t   px;
      logic [15:0] entry;
      case (color_mode)
        MODE_GREY: begin
          px = '{idx, 1'b0, c0, c0, c0, 1'b1};
          queue_rgb(px);
        end
        MODE_RGB: begin
          px = '{idx, 1'b0, c0, c1, c2, 1'b1};
          queue_rgb(px);
        end
        MODE_GBR: begin
          px = '{idx, 1'b0, c2, c0, c1, 1'b1};
          queue_rgb(px);
        end
        MODE_YUV422: begin
          queue_rgb(yuv_to_rgb(idx, 1'b0, 1'b1, c0, c1, c2));
        end
        MODE_YUV420: begin
          if (!odd) begin
            line_store[idx] = {c1, c0};
            store_valid[idx] = 1'b1;
          end else begin
            entry = line_store[idx];
            queue_rgb(yuv_to_rgb(idx, 1'b0, 1'b0, entry[7:0], entry[15:8], c1));
            queue_rgb(yuv_to_rgb(idx, 1'b1, 1'b1, c0, entry[15:8], c1));
          end
        end
        MODE_PAIRED: begin
          queue_rgb(yuv_to_rgb(idx, 1'b0, 1'b0, c0, c1, c2));
          queue_rgb(yuv_to_rgb(idx, 1'b1, 1'b1, c3, c1, c2));
        end
        default: begin
        end
      endcase
    endfunction

    function void report(string field, int want, int got);
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_pixel(rgb_item_t got);
      rgb_item_t want;
      if (pending_rgb.size() == 0) begin
        $display("%0t: unexpected item, expected none actual index %0d row %0d", $time,
                 got.index, got.row);
        errors++;
        return;
      end
      want = pending_rgb.pop_front();
      if (got.index !== want.index) report("index", want.index, got.index);
      if (got.row !== want.row) report("row", want.row, got.row);
      if (got.red !== want.red) report("red", want.red, got.red);
      if (got.green !== want.green) report("green", want.green, got.green);
      if (got.blue !== want.blue) report("blue", want.blue, got.blue);
      if (got.last !== want.last) report("last", want.last, got.last);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [2:0] cfg_wr_data = 3'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [8:0] in_pixel_index = 9'd0;
  logic       in_odd_line = 1'b0;
  logic [7:0] in_comp0 = 8'd0;
  logic [7:0] in_comp1 = 8'd0;
  logic [7:0] in_comp2 = 8'd0;
  logic [7:0] in_comp3 = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [8:0] out_index;
  logic       out_row;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       out_last;

  pixel_scoreboard sb = new();
  int burst_left = 0;
  int pixels_sent = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int stall_period = 1;
  stall_style_t stall_style = STALL_NONE;

  always #5 clk = ~clk;

  scan_line_color_converter_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_index (in_pixel_index),
    .in_odd_line    (in_odd_line),
    .in_comp0       (in_comp0),
    .in_comp1       (in_comp1),
    .in_comp2       (in_comp2),
    .in_comp3       (in_comp3),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_index      (out_index),
    .out_row        (out_row),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_last       (out_last)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_pixel('{out_index, out_row, out_red, out_green, out_blue, out_last});
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
      stall_period = $urandom_range(1, 8);
    end
    stall_left--;
    case (stall_style)
      STALL_NONE: out_stall <= 1'b0;
      STALL_HALF: out_stall <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
      default: out_stall <= (((stall_left / stall_period) % 2) == 1);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_pixel(logic [8:0] idx, logic odd, logic [7:0] c0, logic [7:0] c1,
                            logic [7:0] c2, logic [7:0] c3);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_pixel_index <= idx;
    in_odd_line <= odd;
    in_comp0 <= c0;
    in_comp1 <= c1;
    in_comp2 <= c2;
    in_comp3 <= c3;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(idx, odd, c0, c1, c2, c3);
    if (sb.color_mode != MODE_SPARE_6 && sb.color_mode != MODE_SPARE_7) pixels_sent++;
  endtask

  task automatic random_pixel();
    logic [8:0] idx;
    logic       odd;
    idx = 9'($urandom);
    odd = 1'($urandom);
    // An odd YUV420 line may only read a store entry that an even line wrote.
    if (sb.color_mode == MODE_YUV420 && !sb.store_valid[idx]) odd = 1'b0;
    send_pixel(idx, odd, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_line_pair(int width);
    logic [8:0] start;
    start = 9'($urandom);
    for (int i = 0; i < width; i++) begin
      send_pixel(start + 9'(i), 1'b0, 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
    end
    for (int i = 0; i < width; i++) begin
      send_pixel(start + 9'(i), 1'b1, 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
    end
  endtask

  task automatic set_mode(logic [2:0] mode);
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    sb.color_mode = mode;
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [2:0] mode;
    int pick;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_pixel(9'd0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(9'd511, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    set_mode(MODE_RGB);
    send_pixel(9'h155, 1'b0, 8'h00, 8'hFF, 8'hA5, 8'h5A);
    set_mode(MODE_GBR);
    send_pixel(9'h0AA, 1'b1, 8'h12, 8'h34, 8'h56, 8'h78);
    set_mode(MODE_YUV422);
    send_pixel(9'd0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(9'd1, 1'b1, 8'd255, 8'd255, 8'd255, 8'd0);
    send_pixel(9'd2, 1'b0, 8'd128, 8'd128, 8'd128, 8'd255);
    // Cr just below and Cb just above the offset check truncation toward zero.
    send_pixel(9'd3, 1'b1, 8'd100, 8'd127, 8'd129, 8'd0);
    set_mode(MODE_YUV420);
    send_pixel(9'd0, 1'b0, 8'd255, 8'd0, 8'd77, 8'd0);
    send_pixel(9'd511, 1'b0, 8'd0, 8'd255, 8'd0, 8'd255);
    send_pixel(9'd0, 1'b1, 8'd0, 8'd255, 8'd0, 8'd0);
    send_pixel(9'd511, 1'b1, 8'd255, 8'd0, 8'd255, 8'd255);
    set_mode(MODE_PAIRED);
    send_pixel(9'd0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(9'd511, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(9'd300, 1'b0, 8'd16, 8'd200, 8'd60, 8'd235);
    // The unused mode codes must swallow items without a result.
    set_mode(MODE_SPARE_6);
    send_pixel(9'd5, 1'b0, 8'd1, 8'd2, 8'd3, 8'd4);
    set_mode(MODE_SPARE_7);
    send_pixel(9'd6, 1'b1, 8'd5, 8'd6, 8'd7, 8'd8);

    pixels_sent = 0;
    for (int phase = 0; pixels_sent < RANDOM_ITEMS; phase++) begin
      if (phase < 8) begin
        mode = 3'(phase);
      end else begin
        pick = $urandom_range(0, 11);
        if (pick < 6) mode = 3'(pick);
        else if (pick < 8) mode = MODE_YUV420;
        else if (pick < 10) mode = MODE_PAIRED;
        else mode = (pick == 10) ? MODE_SPARE_6 : MODE_SPARE_7;
      end
      set_mode(mode);
      if (mode == MODE_YUV420) begin
        repeat ($urandom_range(1, 4)) begin
          send_line_pair(($urandom_range(0, 29) == 0) ? 512 : $urandom_range(1, 24));
        end
        repeat ($urandom_range(0, 6)) random_pixel();
      end else if (mode == MODE_SPARE_6 || mode == MODE_SPARE_7) begin
        repeat ($urandom_range(1, 5)) random_pixel();
      end else begin
        repeat ($urandom_range(10, 80)) random_pixel();
      end
    end

    in_valid <= 1'b0;
    while (sb.pending_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_rgb.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/sclc_pkg.sv
design/sclc_ram.sv
design/sclc_yuv_stage.sv
design/sclc_out_buf.sv
design/scan_line_color_converter_unit.sv
tb/sv/scan_line_color_converter_unit_test.sv
